/* hdl/bhc_pkg.sv */
// Shared types, codes and tables for the Hall commutator with duty ramp.
`timescale 1ns / 1ps

package bhc_pkg;

  // Event kinds carried on the input tuser
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_EDGE    = 2'd1;
  localparam logic [1:0] KIND_STOP    = 2'd2;

  // Phase drive modes
  localparam logic [1:0] DRV_OFF  = 2'd0;
  localparam logic [1:0] DRV_HIGH = 2'd1;
  localparam logic [1:0] DRV_LOW  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_TIMER_PERIOD = 2'd0;
  localparam logic [1:0] REG_MAX_DUTY     = 2'd1;
  localparam logic [1:0] REG_DUTY_SLEW    = 2'd2;

  // Register reset values
  localparam logic [15:0] TIMER_PERIOD_RST = 16'd4499;
  localparam logic [6:0]  MAX_DUTY_RST     = 7'd95;
  localparam logic [6:0]  DUTY_SLEW_RST    = 7'd2;

  // Duty ceiling in percent
  localparam logic [6:0] DUTY_FULL = 7'd100;

  // Width of duty * period (7 x 16 bits)
  localparam int PROD_W = 23;

  // floor(p / 100) == (p * DIV_MULT) >> DIV_SHIFT for every p below 2^23
  localparam int DIV_SHIFT = 30;
  localparam int MULT_W    = 24;
  localparam logic [MULT_W-1:0] DIV_MULT = 24'd10737419;

  typedef struct packed {
    logic [1:0] a;
    logic [1:0] b;
    logic [1:0] c;
  } drive_set_t;

  // Everything the scaling stage needs for one result item
  typedef struct packed {
    logic [PROD_W-1:0] product;
    drive_set_t        drive;
    logic [6:0]        applied;
    logic              invalid;
  } mid_t;

  // Six-step table, indexed by Hall bits C B A
  function automatic drive_set_t phase_lookup(input logic [2:0] hall);
    drive_set_t d;
    unique case (hall)
      3'd1:    d = '{a: DRV_HIGH, b: DRV_LOW,  c: DRV_OFF};
      3'd2:    d = '{a: DRV_LOW,  b: DRV_OFF,  c: DRV_HIGH};
      3'd3:    d = '{a: DRV_HIGH, b: DRV_OFF,  c: DRV_LOW};
      3'd4:    d = '{a: DRV_OFF,  b: DRV_HIGH, c: DRV_LOW};
      3'd5:    d = '{a: DRV_OFF,  b: DRV_LOW,  c: DRV_HIGH};
      3'd6:    d = '{a: DRV_LOW,  b: DRV_HIGH, c: DRV_OFF};
      default: d = '{a: DRV_OFF,  b: DRV_OFF,  c: DRV_OFF};
    endcase
    return d;
  endfunction

endpackage

/* hdl/bhc_event.sv */
// Event decode: duty clamp and ramp, Hall table lookup, duty times period.
`timescale 1ns / 1ps

module bhc_event (
  input  logic [1:0]          kind,
  input  logic [7:0]          duty_request,
  input  logic [2:0]          hall_code,
  input  logic [6:0]          duty_now,
  input  logic [15:0]         timer_period,
  input  logic [6:0]          max_duty,
  input  logic [6:0]          duty_slew,
  output logic [6:0]          duty_next,
  output logic                emit,
  output bhc_pkg::mid_t       mid
);

  logic [6:0] cap;
  logic [6:0] target;
  logic [6:0] gap;
  logic [6:0] ramped;
  logic [6:0] duty_sel;
  logic       drive_on;
  logic       bad_hall;
  bhc_pkg::drive_set_t phase;

  // Clamp the request, then step toward it, saturating at the target
  always_comb begin
    cap    = (max_duty > bhc_pkg::DUTY_FULL) ? bhc_pkg::DUTY_FULL : max_duty;
    target = (duty_request > {1'b0, cap}) ? cap : duty_request[6:0];
    ramped = duty_now;
    gap    = 7'd0;
    if (duty_now < target) begin
      gap    = target - duty_now;
      ramped = (gap <= duty_slew) ? target : duty_now + duty_slew;
    end else if (duty_now > target) begin
      gap    = duty_now - target;
      ramped = (gap <= duty_slew) ? target : duty_now - duty_slew;
    end
  end

  assign bad_hall = (hall_code == 3'd0) || (hall_code == 3'd7);
  assign phase    = bhc_pkg::phase_lookup(hall_code);

  // Result selection per event kind
  always_comb begin
    duty_next = duty_now;
    emit      = 1'b0;
    drive_on  = 1'b0;
    duty_sel  = duty_now;
    mid       = '0;
    unique case (kind)
      bhc_pkg::KIND_REQUEST: begin
        drive_on = 1'b1;
        duty_sel = ramped;
      end
      bhc_pkg::KIND_EDGE: begin
        drive_on = (duty_now != 7'd0);
      end
      bhc_pkg::KIND_STOP: begin
        emit      = 1'b1;
        duty_next = 7'd0;
      end
      default: begin
      end
    endcase
    if (drive_on) begin
      emit = 1'b1;
      if (bad_hall) begin
        duty_next   = 7'd0;
        mid.invalid = 1'b1;
      end else begin
        duty_next   = duty_sel;
        mid.drive   = phase;
        mid.applied = duty_sel;
        mid.product = bhc_pkg::PROD_W'(duty_sel) * bhc_pkg::PROD_W'(timer_period);
      end
    end
  end

endmodule

/* hdl/bhc_scale.sv */
// Output stage: divide by 100 through a reciprocal, route compares, hold item.
`timescale 1ns / 1ps

module bhc_scale (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  bhc_pkg::mid_t mid,
  output logic          in_ready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [63:0]   m_tdata,
  output logic [0:0]    m_tuser
);

  localparam int WIDE_W = bhc_pkg::PROD_W + bhc_pkg::MULT_W;

  logic [WIDE_W-1:0] wide;
  logic [15:0]       quot;
  logic [15:0]       cmp_a;
  logic [15:0]       cmp_b;
  logic [15:0]       cmp_c;
  logic [63:0]       data_next;

  // floor(product / 100)
  assign wide = WIDE_W'(mid.product) * WIDE_W'(bhc_pkg::DIV_MULT);
  assign quot = wide[bhc_pkg::DIV_SHIFT +: 16];

  // Only the phase driven high carries the compare value
  assign cmp_a = (mid.drive.a == bhc_pkg::DRV_HIGH) ? quot : 16'd0;
  assign cmp_b = (mid.drive.b == bhc_pkg::DRV_HIGH) ? quot : 16'd0;
  assign cmp_c = (mid.drive.c == bhc_pkg::DRV_HIGH) ? quot : 16'd0;

  assign data_next = {3'd0, mid.applied, mid.drive.c, mid.drive.b, mid.drive.a,
                      cmp_c, cmp_b, cmp_a};

  assign in_ready = !m_tvalid || m_tready;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m_tdata <= data_next;
      m_tuser <= mid.invalid;
    end
  end

endmodule

/* hdl/bldc_hall_commutator_with_ramp_unit.sv */
// Top level of the six-step Hall commutator with duty ramp.
`timescale 1ns / 1ps

// Six-step Hall commutator with duty ramp.
// Input items arrive on s_tvalid/s_tready: s_tuser holds the event kind
// (duty request, Hall edge, stop), s_tdata the requested duty and Hall code.
// Each result item on m_tvalid/m_tready carries the three phase compares,
// the three drive modes, the applied duty, and in m_tuser the invalid Hall flag.
// A Hall edge while the duty is zero, and an unused kind, give no result.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// The input register loads at acceptance, the event stage (ramp and
// duty * period) ends in the event stage register and the scaling stage
// (divide by 100 through a reciprocal multiply) in the result register,
// which drives m_tvalid. Throughput is one item per cycle while the receiver
// does not stall; the kept duty updates as an item leaves the input register,
// so the next item sees it in the following cycle.
// When the receiver stalls, the result register holds its item and the
// stall walks back one stage at a time; s_tready falls once all stages are
// full. Reset clears all valid flags and the kept duty and loads the
// register defaults (period 4499, max duty 95, ramp step 2).

module bldc_hall_commutator_with_ramp_unit (
  input  logic        clk,
  input  logic        rst,
  // input item
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // duty_request[7:0], hall_code[10:8], zero pad
  input  logic [1:0]  s_tuser,  // kind[1:0]
  // result item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // compare_a, compare_b, compare_c, drive_a,
                                // drive_b, drive_c, applied_duty[60:54], zero pad
  output logic [0:0]  m_tuser,  // invalid_hall
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] timer_period;
  logic [6:0]  max_duty;
  logic [6:0]  duty_slew;
  logic [6:0]  duty_now;
  logic [6:0]  duty_next;

  logic        in_valid;
  logic [1:0]  in_kind;
  logic [7:0]  in_req;
  logic [2:0]  in_hall;

  logic          mid_valid;
  bhc_pkg::mid_t mid;
  bhc_pkg::mid_t mid_next;
  logic          emit;
  logic          mid_adv;
  logic          scale_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period <= bhc_pkg::TIMER_PERIOD_RST;
      max_duty     <= bhc_pkg::MAX_DUTY_RST;
      duty_slew    <= bhc_pkg::DUTY_SLEW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bhc_pkg::REG_TIMER_PERIOD: timer_period <= cfg_data;
        bhc_pkg::REG_MAX_DUTY:     max_duty     <= cfg_data[6:0];
        bhc_pkg::REG_DUTY_SLEW:    duty_slew    <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Stage handshakes
  assign mid_adv  = !mid_valid || scale_ready;
  assign s_tready = !in_valid || mid_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind <= s_tuser;
      in_req  <= s_tdata[7:0];
      in_hall <= s_tdata[10:8];
    end
  end

  bhc_event u_event (
    .kind         (in_kind),
    .duty_request (in_req),
    .hall_code    (in_hall),
    .duty_now     (duty_now),
    .timer_period (timer_period),
    .max_duty     (max_duty),
    .duty_slew    (duty_slew),
    .duty_next    (duty_next),
    .emit         (emit),
    .mid          (mid_next)
  );

  // Kept duty and event stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_now  <= 7'd0;
      mid_valid <= 1'b0;
    end else if (mid_adv) begin
      mid_valid <= in_valid && emit;
      if (in_valid) begin
        duty_now <= duty_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv && in_valid) begin
      mid <= mid_next;
    end
  end

  bhc_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mid_valid),
    .mid      (mid),
    .in_ready (scale_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Checks
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    duty_now <= bhc_pkg::DUTY_FULL)
    else $error("kept duty above full scale");

  a_out_duty_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[60:54] <= bhc_pkg::DUTY_FULL))
    else $error("applied duty above full scale");

  a_invalid_is_off: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[60:0] == 61'd0))
    else $error("invalid Hall result with drive or duty set");

  a_one_high_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones({m_tdata[48], m_tdata[50], m_tdata[52]}) <= 1)
                 && (m_tdata[49:48] != 2'd3) && (m_tdata[51:50] != 2'd3)
                 && (m_tdata[53:52] != 2'd3))
    else $error("bad drive pattern");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the six-step Hall commutator with duty ramp.
`timescale 1ns / 1ps

module tb_top;

  // Event code the block must drop without a result
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned SEGMENT_ITEMS = 90;

  typedef struct packed {
    logic [15:0]         cmp_a;
    logic [15:0]         cmp_b;
    logic [15:0]         cmp_c;
    bhc_pkg::drive_set_t drive;
    logic [6:0]          applied;
    logic                invalid;
  } phase_out_t;

  // Tracks kept duty and registers, queues the phase outputs each event should give
  class phase_drive_tracker;
    logic [15:0]  period;
    logic [6:0]   duty_cap;
    logic [6:0]   step;
    int unsigned  duty;
    phase_out_t   due[$];
    int unsigned  errors;

    function new();
      period = bhc_pkg::TIMER_PERIOD_RST;
      duty_cap = bhc_pkg::MAX_DUTY_RST;
      step = bhc_pkg::DUTY_SLEW_RST;
      duty = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        bhc_pkg::REG_TIMER_PERIOD: period = val;
        bhc_pkg::REG_MAX_DUTY:     duty_cap = val[6:0];
        bhc_pkg::REG_DUTY_SLEW:    step = val[6:0];
        default: ;
      endcase
    endfunction

    // Phase pattern and compares for a Hall code at the kept duty
    function phase_out_t drive_for(logic [2:0] hall);
      phase_out_t r;
      logic [15:0] cmp;
      r = '0;
      case (hall)
        3'd1: r.drive = {bhc_pkg::DRV_HIGH, bhc_pkg::DRV_LOW,  bhc_pkg::DRV_OFF};
        3'd2: r.drive = {bhc_pkg::DRV_LOW,  bhc_pkg::DRV_OFF,  bhc_pkg::DRV_HIGH};
        3'd3: r.drive = {bhc_pkg::DRV_HIGH, bhc_pkg::DRV_OFF,  bhc_pkg::DRV_LOW};
        3'd4: r.drive = {bhc_pkg::DRV_OFF,  bhc_pkg::DRV_HIGH, bhc_pkg::DRV_LOW};
        3'd5: r.drive = {bhc_pkg::DRV_OFF,  bhc_pkg::DRV_LOW,  bhc_pkg::DRV_HIGH};
        3'd6: r.drive = {bhc_pkg::DRV_LOW,  bhc_pkg::DRV_HIGH, bhc_pkg::DRV_OFF};
        default: begin
          // bad Hall code forces a stop
          duty = 0;
          r.invalid = 1'b1;
          return r;
        end
      endcase
      cmp = 16'((duty * period) / 100);
      r.cmp_a = (r.drive.a == bhc_pkg::DRV_HIGH) ? cmp : 16'd0;
      r.cmp_b = (r.drive.b == bhc_pkg::DRV_HIGH) ? cmp : 16'd0;
      r.cmp_c = (r.drive.c == bhc_pkg::DRV_HIGH) ? cmp : 16'd0;
      r.applied = duty[6:0];
      return r;
    endfunction

    function void take_event(logic [1:0] kind, logic [7:0] req, logic [2:0] hall);
      phase_out_t r;
      int unsigned cap;
      int unsigned target;
      r = '0;
      case (kind)
        bhc_pkg::KIND_REQUEST: begin
          cap = (duty_cap > bhc_pkg::DUTY_FULL) ? bhc_pkg::DUTY_FULL : duty_cap;
          target = (req > cap) ? cap : req;
          // ramp toward target, landing on it when within one step
          if (duty < target)
            duty = (target - duty <= step) ? target : duty + step;
          else if (duty > target)
            duty = (duty - target <= step) ? target : duty - step;
          due.push_back(drive_for(hall));
        end
        bhc_pkg::KIND_EDGE: begin
          if (duty != 0) due.push_back(drive_for(hall));
        end
        bhc_pkg::KIND_STOP: begin
          duty = 0;
          due.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void match(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_drive(logic [63:0] data, logic user);
      phase_out_t want;
      if (due.size() == 0) begin
        $error("result item with nothing outstanding");
        errors++;
        return;
      end
      want = due.pop_front();
      match("compare_a", want.cmp_a, data[15:0]);
      match("compare_b", want.cmp_b, data[31:16]);
      match("compare_c", want.cmp_c, data[47:32]);
      match("drive_a", want.drive.a, data[49:48]);
      match("drive_b", want.drive.b, data[51:50]);
      match("drive_c", want.drive.c, data[53:52]);
      match("applied_duty", want.applied, data[60:54]);
      match("invalid_hall", want.invalid, user);
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function int unsigned wrap_up();
      if (due.size() != 0) $error("%0d result items never arrived", due.size());
      return errors + due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  phase_drive_tracker drives;
  int unsigned src_gap = 0;
  int unsigned sink_stall = 0;
  int unsigned cycles = 0;
  logic [7:0]  duty_goal = 8'd60;

  bldc_hall_commutator_with_ramp_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Result side: random back-pressure, check every accepted item
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) drives.check_drive(m_tdata, m_tuser[0]);
      m_tready <= ($urandom_range(99) >= sink_stall);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [7:0] req,
                           input logic [2:0] hall);
    while ($urandom_range(99) < src_gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {5'd0, hall, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    drives.take_event(kind, req, hall);
  endtask

  // Drop valid, wait out every result and any item still in the pipe
  task automatic settle();
    s_tvalid <= 1'b0;
    while (drives.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] period, input logic [6:0] cap,
                            input logic [6:0] step);
    cfg_we <= 1'b1;
    cfg_index <= bhc_pkg::REG_TIMER_PERIOD;
    cfg_data <= period;
    @(posedge clk);
    drives.set_reg(bhc_pkg::REG_TIMER_PERIOD, period);
    cfg_index <= bhc_pkg::REG_MAX_DUTY;
    cfg_data <= {9'd0, cap};
    @(posedge clk);
    drives.set_reg(bhc_pkg::REG_MAX_DUTY, {9'd0, cap});
    cfg_index <= bhc_pkg::REG_DUTY_SLEW;
    cfg_data <= {9'd0, step};
    @(posedge clk);
    drives.set_reg(bhc_pkg::REG_DUTY_SLEW, {9'd0, step});
    cfg_we <= 1'b0;
  endtask

  // Mostly ramping requests and edges on valid codes, plus stops and noise
  task automatic random_item(output bit counted);
    int unsigned pick;
    logic [1:0]  kind;
    logic [7:0]  req;
    logic [2:0]  hall;
    pick = $urandom_range(99);
    hall = 3'($urandom_range(6, 1));
    if ($urandom_range(9) == 0)
      duty_goal = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                           : 8'($urandom_range(100));
    req = duty_goal;
    if (pick < 55) begin
      kind = bhc_pkg::KIND_REQUEST;
    end else if (pick < 80) begin
      kind = bhc_pkg::KIND_EDGE;
    end else if (pick < 86) begin
      kind = bhc_pkg::KIND_STOP;
      req = 8'($urandom);
      hall = 3'($urandom);
    end else if (pick < 92) begin
      kind = $urandom_range(1) ? bhc_pkg::KIND_EDGE : bhc_pkg::KIND_REQUEST;
      hall = $urandom_range(1) ? 3'd7 : 3'd0;
    end else if (pick < 97) begin
      kind = bhc_pkg::KIND_REQUEST;
      req = 8'($urandom);
      hall = 3'($urandom);
    end else begin
      kind = KIND_UNUSED;
      req = 8'($urandom);
      hall = 3'($urandom);
    end
    send_item(kind, req, hall);
    counted = (kind != KIND_UNUSED);
  endtask

  initial begin
    int unsigned sent;
    bit counted;
    drives = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset registers, duty starts at zero
    send_item(bhc_pkg::KIND_EDGE, 8'd0, 3'd1);       // edge at zero duty: silent
    send_item(KIND_UNUSED, 8'hFF, 3'd7);             // unused kind: silent
    send_item(bhc_pkg::KIND_REQUEST, 8'hFF, 3'd1);   // clamp, ramp by one step
    send_item(bhc_pkg::KIND_EDGE, 8'd0, 3'd2);
    send_item(bhc_pkg::KIND_EDGE, 8'd0, 3'd3);
    send_item(bhc_pkg::KIND_EDGE, 8'd0, 3'd4);
    send_item(bhc_pkg::KIND_EDGE, 8'd0, 3'd5);
    send_item(bhc_pkg::KIND_EDGE, 8'd0, 3'd6);
    send_item(bhc_pkg::KIND_EDGE, 8'd0, 3'd0);       // bad Hall code on edge
    send_item(bhc_pkg::KIND_REQUEST, 8'd1, 3'd3);
    send_item(bhc_pkg::KIND_REQUEST, 8'hFF, 3'd7);   // bad Hall code on request
    send_item(bhc_pkg::KIND_REQUEST, 8'd10, 3'd4);
    send_item(bhc_pkg::KIND_REQUEST, 8'd10, 3'd4);
    send_item(bhc_pkg::KIND_REQUEST, 8'd0, 3'd5);
    send_item(bhc_pkg::KIND_REQUEST, 8'd1, 3'd6);    // downward step stops at target
    send_item(bhc_pkg::KIND_STOP, 8'hAA, 3'd7);
    send_item(bhc_pkg::KIND_EDGE, 8'd0, 3'd2);       // silent after stop
    settle();

    // Full period, clamp above 100, step above 100
    write_regs(16'hFFFF, 7'd127, 7'd127);
    send_item(bhc_pkg::KIND_REQUEST, 8'hFF, 3'd1);
    send_item(bhc_pkg::KIND_REQUEST, 8'd0, 3'd6);
    send_item(bhc_pkg::KIND_EDGE, 8'd0, 3'd3);
    send_item(bhc_pkg::KIND_REQUEST, 8'd200, 3'd4);
    settle();

    // Zero period and zero step: duty frozen, compares zero
    write_regs(16'd0, 7'd100, 7'd0);
    send_item(bhc_pkg::KIND_REQUEST, 8'd50, 3'd5);
    send_item(bhc_pkg::KIND_EDGE, 8'd0, 3'd1);
    settle();

    // Zero clamp pulls the duty down
    write_regs(16'd12345, 7'd0, 7'd50);
    send_item(bhc_pkg::KIND_REQUEST, 8'd80, 3'd2);
    send_item(bhc_pkg::KIND_REQUEST, 8'd80, 3'd2);
    settle();

    // Random segments: register setting and idling pattern per segment
    for (int seg = 0; seg < 6; seg++) begin
      src_gap = (seg < 2) ? 7 : (seg < 4) ? 73 : 0;
      sink_stall = (seg < 2) ? 73 : (seg < 4) ? 7 : 0;
      case (seg)
        0: write_regs(16'hFFFF, 7'd127, 7'd127);
        1: write_regs(16'd1, 7'd100, 7'd1);
        3: write_regs(bhc_pkg::TIMER_PERIOD_RST, bhc_pkg::MAX_DUTY_RST, 7'd3);
        default: write_regs(16'($urandom), 7'($urandom_range(127)),
                            7'($urandom_range(127)));
      endcase
      sent = 0;
      while (sent < SEGMENT_ITEMS) begin
        random_item(counted);
        if (counted) sent++;
      end
      settle();
    end

    if (drives.wrap_up() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
hdl/bhc_pkg.sv
hdl/bhc_event.sv
hdl/bhc_scale.sv
hdl/bldc_hall_commutator_with_ramp_unit.sv
verif/tb_top.sv
